/* src/ssm_pkg.sv */
// Shared types, field widths and operation codes for the sparse set membership block.
package ssm_pkg;

   // Field widths of the request and response beats
   localparam int FUNC_W  = 2;
   localparam int KEY_W   = 10;
   localparam int POS_W   = 8;
   localparam int COUNT_W = 9;

   // Default size of the key universe
   localparam int UNIVERSE_DEFAULT = 256;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [KEY_W-1:0]  key;
   } ssm_req_type;

   typedef struct packed {
      logic               ok;
      logic [POS_W-1:0]   position;
      logic [COUNT_W-1:0] member_count;
   } ssm_rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic init;     // zero one entry of both memories after reset
      logic capture;  // latch the request, read the sparse slot
      logic rd_slot;  // read dense entry at the sparse slot
      logic rd_last;  // read dense entry of the last member
      logic ins;      // append the key
      logic rem;      // move the last member into the freed slot
      logic clr;      // zero the count
      logic reply;    // register the response beat
   } ssm_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              found;
      logic              can_insert;
      logic              init_last;
   } ssm_status_type;

endpackage

/* src/ssm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ssm_ram import ssm_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ssm_ctrl.sv */
// Controller state machine that sequences the memory accesses of one operation.
module ssm_ctrl import ssm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  ssm_status_type status,
   output ssm_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SPARSE = 3'd1;
   localparam logic [2:0] ST_DENSE  = 3'd2;
   localparam logic [2:0] ST_LAST   = 3'd3;
   localparam logic [2:0] ST_INIT   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_INIT: begin
            // clearing pass over both memories
            cmd.init = 1'b1;
            if (status.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_SPARSE;
            end
         end
         ST_SPARSE: begin
            cmd.rd_slot = 1'b1;
            state_in    = ST_DENSE;
         end
         ST_DENSE: begin
            state_in = ST_IDLE;
            unique case (status.func)
               FUNC_INSERT: begin
                  cmd.ins   = status.can_insert;
                  cmd.reply = 1'b1;
               end
               FUNC_REMOVE: begin
                  if (status.found) begin
                     cmd.rd_last = 1'b1;
                     state_in    = ST_LAST;
                  end else begin
                     cmd.reply = 1'b1;
                  end
               end
               FUNC_LOOKUP: begin
                  cmd.reply = 1'b1;
               end
               FUNC_CLEAR: begin
                  cmd.clr   = 1'b1;
                  cmd.reply = 1'b1;
               end
               default: begin
                  cmd.reply = 1'b1;
               end
            endcase
         end
         ST_LAST: begin
            cmd.rem   = 1'b1;
            cmd.reply = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* src/ssm_datapath.sv */
// Datapath: dense and sparse memories, member count, membership test and response register.
module ssm_datapath import ssm_pkg::*; #(
   parameter int UNIVERSE = UNIVERSE_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  ssm_req_type    req_item,
   input  ssm_cmd_type    cmd,
   output ssm_status_type status,
   output logic           rsp_strobe,
   output ssm_rsp_type    rsp_item
);

   localparam int SLOT_W = $clog2(UNIVERSE);
   localparam int CNT_W  = $clog2(UNIVERSE + 1);

   ssm_req_type        op_ff;
   logic               in_range_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_strobe_ff;
   ssm_rsp_type        rsp_ff;
   ssm_rsp_type        rsp_in;
   logic [SLOT_W-1:0]  init_addr_ff;
   logic [SLOT_W-1:0]  init_addr_in;

   logic [SLOT_W-1:0]  slot;
   logic [KEY_W-1:0]   dense_rd;
   logic               found;
   logic               can_insert;
   logic               lookup_hit;
   logic               init_last;

   logic               dense_rd_en;
   logic [SLOT_W-1:0]  dense_rd_addr;
   logic               mem_we;
   logic [SLOT_W-1:0]  dense_wr_addr;
   logic [KEY_W-1:0]   dense_wr_data;
   logic [SLOT_W-1:0]  sparse_wr_addr;
   logic [SLOT_W-1:0]  sparse_wr_data;

   // Latch the operation and its range check
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_item;
         in_range_ff <= (32'(req_item.key) < UNIVERSE);
      end
   end

   // Clearing pass after reset: one entry of each memory per cycle
   assign init_addr_in = cmd.init ? init_addr_ff + SLOT_W'(1) : init_addr_ff;
   assign init_last    = (init_addr_ff == SLOT_W'(UNIVERSE - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         init_addr_ff <= '0;
      end else begin
         init_addr_ff <= init_addr_in;
      end
   end

   // Memory addressing: sparse read at capture, dense read at slot or last member
   assign dense_rd_en    = cmd.rd_slot | cmd.rd_last;
   assign dense_rd_addr  = cmd.rd_slot ? slot : SLOT_W'(count_ff - CNT_W'(1));
   assign mem_we         = cmd.ins | cmd.rem | cmd.init;
   assign dense_wr_addr  = cmd.init ? init_addr_ff : (cmd.ins ? SLOT_W'(count_ff) : slot);
   assign dense_wr_data  = cmd.init ? '0 : (cmd.ins ? op_ff.key : dense_rd);
   assign sparse_wr_addr = cmd.init ? init_addr_ff :
                           (cmd.ins ? SLOT_W'(op_ff.key) : SLOT_W'(dense_rd));
   assign sparse_wr_data = cmd.init ? '0 : (cmd.ins ? SLOT_W'(count_ff) : slot);

   ssm_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (UNIVERSE)
   ) u_sparse (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (sparse_wr_addr),
      .wr_data (sparse_wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (SLOT_W'(req_item.key)),
      .rd_data (slot)
   );

   ssm_ram #(
      .WIDTH (KEY_W),
      .DEPTH (UNIVERSE)
   ) u_dense (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (dense_wr_addr),
      .wr_data (dense_wr_data),
      .rd_en   (dense_rd_en),
      .rd_addr (dense_rd_addr),
      .rd_data (dense_rd)
   );

   // Membership: key in range, slot below count and dense entry matches the key
   assign found      = in_range_ff && (CNT_W'(slot) < count_ff) && (dense_rd == op_ff.key);
   assign can_insert = in_range_ff && !found && (count_ff < CNT_W'(UNIVERSE));
   assign lookup_hit = (op_ff.func == FUNC_LOOKUP) && found;

   assign status.func       = op_ff.func;
   assign status.found      = found;
   assign status.can_insert = can_insert;
   assign status.init_last  = init_last;

   // Count update
   always_comb begin
      count_in = count_ff;
      if (cmd.clr) begin
         count_in = '0;
      end else if (cmd.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Response beat
   always_comb begin
      rsp_in.ok           = cmd.ins | cmd.rem | lookup_hit;
      rsp_in.position     = '0;
      if (cmd.ins) begin
         rsp_in.position = POS_W'(count_ff);
      end else if (lookup_hit) begin
         rsp_in.position = POS_W'(slot);
      end
      rsp_in.member_count = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.reply;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reply) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(UNIVERSE))
      else $error("member count above universe");

   a_remove_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.rem |-> count_ff != '0)
      else $error("remove on empty set");

   a_single_update: assert property (@(posedge clock) disable iff (reset)
      (cmd.ins || cmd.rem || cmd.clr) |-> (cmd.reply && $onehot({cmd.ins, cmd.rem, cmd.clr})))
      else $error("set update without a single reply");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow count");
`endif

endmodule

/* src/sparse_set_membership.sv */
// Top level of the sparse set membership block: controller and datapath.
//
//   channel  ports                      beat moves on
//   request  start, busy, req_item      start high while busy low
//   response rsp_strobe, rsp_item       rsp_strobe high, one cycle
//
// The response strobe rises after the SPARSE and DENSE states, and after LAST
// too for a remove that finds its key; busy drops so that the next beat can be
// accepted at the edge that takes the response. The dependent sparse-then-dense
// reads on the single read port of each memory set that order. After reset busy
// is high while UNIVERSE entries (256 by default) of both memories are zeroed, one
// entry a cycle; reset also clears the count. The response has no back-pressure.
module sparse_set_membership import ssm_pkg::*; #(
   parameter int UNIVERSE = UNIVERSE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  ssm_req_type req_item,
   output logic        rsp_strobe,
   output ssm_rsp_type rsp_item
);

   ssm_cmd_type    cmd;
   ssm_status_type status;

   ssm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ssm_datapath #(
      .UNIVERSE (UNIVERSE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the sparse set membership block: directed and random operations.
module tb_top;
   import ssm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int UNIVERSE   = UNIVERSE_DEFAULT;
   localparam int ITEM_GOAL  = 1550;
   localparam int DRAIN_MAX  = 2000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   ssm_req_type req_item;
   logic        rsp_strobe;
   ssm_rsp_type rsp_item;

   // Operations waiting to be sent, replies waiting to come back
   ssm_req_type op_backlog[$];
   ssm_rsp_type pending_replies[$];

   // Shadow copy of the set
   logic [POS_W-1:0] shadow_dense  [UNIVERSE];
   logic [POS_W-1:0] shadow_sparse [UNIVERSE];
   int unsigned      shadow_count;

   int unsigned gap_left;
   int unsigned quiet_run;
   int unsigned error_count;

   sparse_set_membership #(.UNIVERSE(UNIVERSE)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Apply one operation to the shadow set and return the reply it should produce.
   // Members always sit in slots below the count with matching sparse entries,
   // so stale memory outside that range cannot change the outcome.
   function automatic ssm_rsp_type apply_set_op(ssm_req_type op);
      ssm_rsp_type reply;
      int unsigned k;
      int unsigned slot;
      bit          present;
      logic [POS_W-1:0] last;
      reply   = '0;
      k       = op.key;
      slot    = 0;
      present = 1'b0;
      if (k < UNIVERSE) begin
         slot    = shadow_sparse[k];
         present = (slot < shadow_count) && (shadow_dense[slot] == k);
      end
      case (op.func)
         FUNC_INSERT: begin
            if (k < UNIVERSE && !present && shadow_count < UNIVERSE) begin
               shadow_dense[shadow_count] = POS_W'(k);
               shadow_sparse[k]           = POS_W'(shadow_count);
               reply.position             = POS_W'(shadow_count);
               shadow_count++;
               reply.ok = 1'b1;
            end
         end
         FUNC_REMOVE: begin
            if (present) begin
               // last member fills the freed slot
               last               = shadow_dense[shadow_count - 1];
               shadow_dense[slot] = last;
               shadow_sparse[last] = POS_W'(slot);
               shadow_count--;
               reply.ok = 1'b1;
            end
         end
         FUNC_LOOKUP: begin
            if (present) begin
               reply.position = POS_W'(slot);
               reply.ok       = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            shadow_count = 0;
         end
      endcase
      reply.member_count = COUNT_W'(shadow_count);
      return reply;
   endfunction

   // Idle length before the next request: mostly short, a few long,
   // with occasional runs of back-to-back beats
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet_run != 0) begin
         quiet_run--;
         return 0;
      end
      roll = $urandom_range(99, 0);
      if (roll == 0) begin
         quiet_run = $urandom_range(80, 20);
         return 0;
      end
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(8, 4);
      return $urandom_range(40, 10);
   endfunction

   task automatic add_op(input logic [FUNC_W-1:0] func, input int unsigned key);
      ssm_req_type op;
      op.func = func;
      op.key  = KEY_W'(key);
      op_backlog.push_back(op);
   endtask

   // Random key: mostly from a narrow window so operations collide
   function automatic int unsigned pick_key(input int unsigned window_base);
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 70) return window_base + $urandom_range(31, 0);
      if (roll < 92) return $urandom_range(UNIVERSE - 1, 0);
      return $urandom_range((1 << KEY_W) - 1, UNIVERSE);
   endfunction

   task automatic add_mixed_op(input int unsigned window_base);
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 36)      add_op(FUNC_INSERT, pick_key(window_base));
      else if (roll < 62) add_op(FUNC_REMOVE, pick_key(window_base));
      else if (roll < 98) add_op(FUNC_LOOKUP, pick_key(window_base));
      else                add_op(FUNC_CLEAR, $urandom_range((1 << KEY_W) - 1, 0));
   endtask

   // Fill the whole universe in random order, poke at the full set, then thin it out
   task automatic add_fill_episode();
      int unsigned order [UNIVERSE];
      int unsigned j;
      int unsigned tmp;
      add_op(FUNC_CLEAR, 0);
      for (int i = 0; i < UNIVERSE; i++) order[i] = i;
      for (int i = UNIVERSE - 1; i > 0; i--) begin
         j        = $urandom_range(i, 0);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < UNIVERSE; i++) add_op(FUNC_INSERT, order[i]);
      add_op(FUNC_INSERT, $urandom_range(UNIVERSE - 1, 0));
      add_op(FUNC_INSERT, UNIVERSE - 1);
      add_op(FUNC_LOOKUP, order[UNIVERSE - 1]);
      add_op(FUNC_LOOKUP, order[0]);
      for (int i = $urandom_range(60, 30); i > 0; i--) begin
         if ($urandom_range(3, 0) == 0) add_op(FUNC_LOOKUP, $urandom_range(UNIVERSE - 1, 0));
         else                           add_op(FUNC_REMOVE, $urandom_range(UNIVERSE - 1, 0));
      end
   endtask

   // Driver: one request beat at a time, start held until accepted
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else begin
         if (start && !busy)
            pending_replies.push_back(apply_set_op(req_item));
         if (!start || !busy) begin
            if (gap_left != 0) begin
               start    <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (op_backlog.size() != 0) begin
               req_item <= op_backlog.pop_front();
               start    <= 1'b1;
               gap_left <= pick_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every response beat against the oldest expected reply
   always @(posedge clock) begin
      ssm_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected response beat: ok %0d position %0d member_count %0d",
                   rsp_item.ok, rsp_item.position, rsp_item.member_count);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_item.ok !== want.ok) begin
               $error("ok: expected %0d, got %0d", want.ok, rsp_item.ok);
               error_count++;
            end
            if (rsp_item.position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_item.position);
               error_count++;
            end
            if (rsp_item.member_count !== want.member_count) begin
               $error("member_count: expected %0d, got %0d",
                      want.member_count, rsp_item.member_count);
               error_count++;
            end
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int unsigned window_base;
      int unsigned next_fill;
      reset        = 1'b1;
      start        = 1'b0;
      req_item     = '0;
      gap_left     = 0;
      quiet_run    = 0;
      error_count  = 0;
      shadow_count = 0;
      for (int i = 0; i < UNIVERSE; i++) begin
         shadow_dense[i]  = '0;
         shadow_sparse[i] = '0;
      end

      // Directed: empty set, key extremes, duplicates, out-of-range keys,
      // remove of the last member and of the first one, clear with stale memory
      add_op(FUNC_LOOKUP, 0);
      add_op(FUNC_REMOVE, 5);
      add_op(FUNC_INSERT, 0);
      add_op(FUNC_INSERT, 255);
      add_op(FUNC_INSERT, 0);
      add_op(FUNC_INSERT, 256);
      add_op(FUNC_INSERT, 1023);
      add_op(FUNC_REMOVE, 1023);
      add_op(FUNC_LOOKUP, 512);
      add_op(FUNC_LOOKUP, 255);
      add_op(FUNC_INSERT, 170);
      add_op(FUNC_INSERT, 85);
      add_op(FUNC_REMOVE, 0);
      add_op(FUNC_LOOKUP, 85);
      add_op(FUNC_LOOKUP, 0);
      add_op(FUNC_REMOVE, 170);
      add_op(FUNC_REMOVE, 255);
      add_op(FUNC_LOOKUP, 85);
      add_op(FUNC_CLEAR, 1023);
      add_op(FUNC_LOOKUP, 85);
      add_op(FUNC_REMOVE, 85);
      add_op(FUNC_INSERT, 170);
      add_op(FUNC_LOOKUP, 170);
      add_op(FUNC_CLEAR, 0);
      add_op(FUNC_CLEAR, 682);

      // Random: mixed operations on a drifting key window, with full fills
      // that only start while a whole episode still fits in the item budget
      window_base = $urandom_range(UNIVERSE - 32, 0);
      next_fill   = $urandom_range(500, 150);
      while (op_backlog.size() < ITEM_GOAL) begin
         if (op_backlog.size() >= next_fill &&
             op_backlog.size() + UNIVERSE + 70 <= ITEM_GOAL) begin
            add_fill_episode();
            next_fill = op_backlog.size() + $urandom_range(800, 500);
         end else begin
            if ($urandom_range(99, 0) == 0) window_base = $urandom_range(UNIVERSE - 32, 0);
            add_mixed_op(window_base);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (op_backlog.size() != 0 || start) @(posedge clock);
      for (int n = 0; n < DRAIN_MAX && pending_replies.size() != 0; n++) @(posedge clock);
      repeat (10) @(posedge clock);

      if (pending_replies.size() != 0) begin
         $error("%0d expected replies never arrived", pending_replies.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
